// File: sv/rc_link_bind_and_hop_sequencer_macros.svh
// Assertion helpers for the link sequencer checks.
// Each one samples on the rising edge of clk and is off while rst_n is low.
`ifndef RC_LINK_BIND_AND_HOP_SEQUENCER_MACROS_SVH
`define RC_LINK_BIND_AND_HOP_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rclb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rclb: next-cycle check failed");

`endif

// File: sv/rclb_pkg.sv
`default_nettype none
package rclb_pkg;

    localparam int NUM_STICKS  = 8;
    localparam int FRAME_BYTES = 20;
    localparam int MAG_W       = 15;
    localparam int PROD_W      = 23;

    localparam int SCALE_GAIN   = 497;
    localparam int SCALE_OFFSET = 1497;

    localparam logic [6:0] RF_BIND_CH      = 7'd3;
    localparam logic [7:0] BIND_MATCH      = 8'h13;
    localparam logic [7:0] BIND_FILL       = 8'h05;
    localparam logic [7:0] BIND_MARK       = 8'h99;
    localparam logic [7:0] BIND_HOLD_TICKS = 8'd27;
    localparam logic [7:0] BIND_FRAMES     = 8'd20;
    localparam logic [7:0] BIND_TAIL_TICKS = 8'd217;

    localparam logic [15:0] RATE_1M   = 16'd0;
    localparam logic [15:0] RATE_250K = 16'd1;
    localparam logic [15:0] MODE_OFF  = 16'd0;
    localparam logic [15:0] MODE_RX   = 16'd1;
    localparam logic [15:0] MODE_TX   = 16'd2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STORE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_TX_ID = 2'd0,
        CFG_HOP1  = 2'd1,
        CFG_HOP2  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_BIND0      = 4'd0,
        PH_BIND1      = 4'd1,
        PH_BIND2      = 4'd2,
        PH_DATA0      = 4'd3,
        PH_DATA1      = 4'd4,
        PH_DATA2      = 4'd5,
        PH_DATA3      = 4'd6,
        PH_DATA4      = 4'd7,
        PH_BIND2_WAIT = 4'd9,
        PH_DATA0_WAIT = 4'd10
    } phase_t;

    typedef enum logic [3:0] {
        ACT_WAIT      = 4'd0,
        ACT_RF_CH     = 4'd1,
        ACT_RATE      = 4'd2,
        ACT_MODE      = 4'd3,
        ACT_ADDR      = 4'd4,
        ACT_PAYLOAD   = 4'd5,
        ACT_READ      = 4'd6,
        ACT_FLUSH     = 4'd7,
        ACT_POWER     = 4'd8,
        ACT_BIND_DONE = 4'd9
    } act_t;

    typedef enum logic [3:0] {
        EM_NONE,
        EM_PRE,
        EM_READ,
        EM_MATCH,
        EM_BDONE,
        EM_ADDR,
        EM_RFCH,
        EM_FLUSH,
        EM_PAY,
        EM_BPAY,
        EM_POWER,
        EM_WAIT
    } emit_t;

    typedef enum logic [2:0] {
        W_START,
        W_LISTEN,
        W_SLOW,
        W_BIND,
        W_HOP,
        W_FRAME,
        W_IDLE
    } wsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE1,
        ST_SCALE2,
        ST_SCALE3,
        ST_PRE,
        ST_READ,
        ST_MATCH,
        ST_BDONE,
        ST_ADDR,
        ST_RFCH,
        ST_FLUSH,
        ST_PAY,
        ST_BPAY,
        ST_POWER,
        ST_WAIT
    } ctl_state_t;

    typedef struct packed {
        logic       accept;
        logic       emit;
        emit_t      em;
        logic [4:0] idx;
        wsel_t      wsel;
        logic       scale1;
        logic       scale2;
        logic       scale3;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        phase_t     phase;
        logic       rx_ready;
        logic       rx_match;
        logic       power_diff;
        logic       out_free;
    } dp_status_t;

    function automatic logic [15:0] wait_us(input wsel_t w);
        logic [15:0] v;
        case (w)
            W_START:  v = 16'd50000;
            W_LISTEN: v = 16'd1000;
            W_SLOW:   v = 16'd10000;
            W_BIND:   v = 16'd22520;
            W_HOP:    v = 16'd2000;
            W_FRAME:  v = 16'd5000;
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/rclb_ctrl.sv
`default_nettype none
module rclb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire rclb_pkg::dp_status_t  status,
    output rclb_pkg::ctl_cmd_t         cmd
);

    rclb_pkg::ctl_state_t state_reg, state_next;
    logic [4:0]           idx_reg, idx_next;
    rclb_pkg::wsel_t      wsel_reg, wsel_next;
    logic                 rx_reg, rx_next;
    logic                 match_reg, match_next;
    logic                 pdiff_reg, pdiff_next;

    logic       accept;
    logic       emitting;
    logic       emit;
    logic [4:0] seg_len;
    logic       seg_done;

    assign accept = s_tvalid && (state_reg == rclb_pkg::ST_IDLE);

    always_comb
    begin
        case (state_reg)
            rclb_pkg::ST_PRE:   seg_len = 5'd3;
            rclb_pkg::ST_MATCH: seg_len = 5'd2;
            rclb_pkg::ST_BDONE: seg_len = 5'd4;
            rclb_pkg::ST_ADDR:  seg_len = 5'd4;
            rclb_pkg::ST_PAY:   seg_len = 5'(rclb_pkg::FRAME_BYTES);
            rclb_pkg::ST_BPAY:  seg_len = 5'(rclb_pkg::FRAME_BYTES);
            default:            seg_len = 5'd1;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            rclb_pkg::ST_IDLE, rclb_pkg::ST_SCALE1, rclb_pkg::ST_SCALE2,
            rclb_pkg::ST_SCALE3: emitting = 1'b0;
            default:             emitting = 1'b1;
        endcase
    end

    assign emit     = emitting && status.out_free;
    assign seg_done = emit && (idx_reg == seg_len - 5'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        wsel_next  = wsel_reg;
        rx_next    = rx_reg;
        match_next = match_reg;
        pdiff_next = pdiff_reg;
        case (state_reg)
            rclb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.op)
                        rclb_pkg::OP_START:
                        begin
                            state_next = rclb_pkg::ST_WAIT;
                            wsel_next  = rclb_pkg::W_START;
                        end
                        rclb_pkg::OP_STORE:
                        begin
                            state_next = rclb_pkg::ST_SCALE1;
                        end
                        rclb_pkg::OP_TICK:
                        begin
                            rx_next    = status.rx_ready;
                            match_next = status.rx_match;
                            pdiff_next = status.power_diff;
                            case (status.phase)
                                rclb_pkg::PH_BIND0, rclb_pkg::PH_BIND1:
                                begin
                                    if (status.phase == rclb_pkg::PH_BIND0)
                                        state_next = rclb_pkg::ST_PRE;
                                    else if (status.rx_ready)
                                        state_next = rclb_pkg::ST_READ;
                                    else
                                        state_next = rclb_pkg::ST_WAIT;
                                    wsel_next = (status.rx_ready && status.rx_match) ?
                                                rclb_pkg::W_SLOW : rclb_pkg::W_LISTEN;
                                end
                                rclb_pkg::PH_BIND2_WAIT, rclb_pkg::PH_DATA0_WAIT:
                                begin
                                    state_next = rclb_pkg::ST_WAIT;
                                    wsel_next  = rclb_pkg::W_SLOW;
                                end
                                rclb_pkg::PH_BIND2:
                                begin
                                    state_next = rclb_pkg::ST_BPAY;
                                    wsel_next  = rclb_pkg::W_BIND;
                                end
                                rclb_pkg::PH_DATA0:
                                begin
                                    state_next = rclb_pkg::ST_BDONE;
                                    wsel_next  = rclb_pkg::W_HOP;
                                end
                                rclb_pkg::PH_DATA1, rclb_pkg::PH_DATA4:
                                begin
                                    state_next = rclb_pkg::ST_ADDR;
                                    wsel_next  = rclb_pkg::W_HOP;
                                end
                                rclb_pkg::PH_DATA2, rclb_pkg::PH_DATA3:
                                begin
                                    state_next = rclb_pkg::ST_FLUSH;
                                    wsel_next  = rclb_pkg::W_FRAME;
                                end
                                default:
                                begin
                                    state_next = rclb_pkg::ST_WAIT;
                                    wsel_next  = rclb_pkg::W_IDLE;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = rclb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rclb_pkg::ST_SCALE1: state_next = rclb_pkg::ST_SCALE2;
            rclb_pkg::ST_SCALE2: state_next = rclb_pkg::ST_SCALE3;
            rclb_pkg::ST_SCALE3: state_next = rclb_pkg::ST_IDLE;
            rclb_pkg::ST_PRE:
                if (seg_done)
                    state_next = rx_reg ? rclb_pkg::ST_READ : rclb_pkg::ST_WAIT;
            rclb_pkg::ST_READ:
                if (seg_done)
                    state_next = match_reg ? rclb_pkg::ST_MATCH : rclb_pkg::ST_WAIT;
            rclb_pkg::ST_MATCH:
                if (seg_done)
                    state_next = rclb_pkg::ST_WAIT;
            rclb_pkg::ST_BDONE:
                if (seg_done)
                    state_next = rclb_pkg::ST_ADDR;
            rclb_pkg::ST_ADDR:
                if (seg_done)
                    state_next = rclb_pkg::ST_RFCH;
            rclb_pkg::ST_RFCH:
                if (seg_done)
                    state_next = rclb_pkg::ST_WAIT;
            rclb_pkg::ST_FLUSH:
                if (seg_done)
                    state_next = rclb_pkg::ST_PAY;
            rclb_pkg::ST_PAY:
                if (seg_done)
                    state_next = pdiff_reg ? rclb_pkg::ST_POWER : rclb_pkg::ST_WAIT;
            rclb_pkg::ST_BPAY:
                if (seg_done)
                    state_next = rclb_pkg::ST_WAIT;
            rclb_pkg::ST_POWER:
                if (seg_done)
                    state_next = rclb_pkg::ST_WAIT;
            rclb_pkg::ST_WAIT:
                if (seg_done)
                    state_next = rclb_pkg::ST_IDLE;
            default:
                state_next = rclb_pkg::ST_IDLE;
        endcase

        if (state_next != state_reg)
            idx_next = 5'd0;
        else if (emit)
            idx_next = idx_reg + 5'd1;
        else
            idx_next = idx_reg;
    end

    // outputs
    always_comb
    begin
        s_tready   = (state_reg == rclb_pkg::ST_IDLE);
        cmd.accept = accept;
        cmd.emit   = emit;
        cmd.idx    = idx_reg;
        cmd.wsel   = wsel_reg;
        cmd.scale1 = (state_reg == rclb_pkg::ST_SCALE1);
        cmd.scale2 = (state_reg == rclb_pkg::ST_SCALE2);
        cmd.scale3 = (state_reg == rclb_pkg::ST_SCALE3);
        case (state_reg)
            rclb_pkg::ST_PRE:   cmd.em = rclb_pkg::EM_PRE;
            rclb_pkg::ST_READ:  cmd.em = rclb_pkg::EM_READ;
            rclb_pkg::ST_MATCH: cmd.em = rclb_pkg::EM_MATCH;
            rclb_pkg::ST_BDONE: cmd.em = rclb_pkg::EM_BDONE;
            rclb_pkg::ST_ADDR:  cmd.em = rclb_pkg::EM_ADDR;
            rclb_pkg::ST_RFCH:  cmd.em = rclb_pkg::EM_RFCH;
            rclb_pkg::ST_FLUSH: cmd.em = rclb_pkg::EM_FLUSH;
            rclb_pkg::ST_PAY:   cmd.em = rclb_pkg::EM_PAY;
            rclb_pkg::ST_BPAY:  cmd.em = rclb_pkg::EM_BPAY;
            rclb_pkg::ST_POWER: cmd.em = rclb_pkg::EM_POWER;
            rclb_pkg::ST_WAIT:  cmd.em = rclb_pkg::EM_WAIT;
            default:            cmd.em = rclb_pkg::EM_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rclb_pkg::ST_IDLE;
            idx_reg   <= 5'd0;
            wsel_reg  <= rclb_pkg::W_IDLE;
            rx_reg    <= 1'b0;
            match_reg <= 1'b0;
            pdiff_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            wsel_reg  <= wsel_next;
            rx_reg    <= rx_next;
            match_reg <= match_next;
            pdiff_reg <= pdiff_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/rclb_dpath.sv
`default_nettype none
module rclb_dpath #(
    parameter int CHANNEL_FULL_SCALE = 10000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic [31:0]         s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic                m_tready,
    input  wire rclb_pkg::ctl_cmd_t  cmd,
    output rclb_pkg::dp_status_t     status,
    output logic                     m_tvalid,
    output logic [23:0]              m_tdata,
    output logic [3:0]               m_tuser,
    output logic                     m_tlast
);

    // floor(p / FS) == (p * RECIP) >> K_SHIFT for every p below 2**PROD_W
    localparam int          K_SHIFT     = rclb_pkg::PROD_W + $clog2(CHANNEL_FULL_SCALE);
    localparam logic [63:0] RECIP_FULL  = ((64'd1 << K_SHIFT) + 64'(CHANNEL_FULL_SCALE)
                                           - 64'd1) / 64'(CHANNEL_FULL_SCALE);
    localparam int          RECIP_W     = rclb_pkg::PROD_W - rclb_pkg::MAG_W + 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int          P2_W        = rclb_pkg::PROD_W + RECIP_W;
    localparam logic [15:0] WORD_ZERO   = 16'(rclb_pkg::SCALE_OFFSET * 8);
    localparam int          SIDX_W      = $clog2(rclb_pkg::NUM_STICKS);

    logic                            in_bind;
    logic [2:0]                      in_power;
    logic [SIDX_W-1:0]               in_chidx;
    logic [rclb_pkg::MAG_W-1:0]      in_value;
    logic                            in_rx_ready;
    logic [7:0]                      in_rx_byte;

    assign in_bind     = s_tdata[0];
    assign in_power    = s_tdata[3:1];
    assign in_chidx    = s_tdata[6:4];
    assign in_value    = s_tdata[21:7];
    assign in_rx_ready = s_tdata[22];
    assign in_rx_byte  = s_tdata[30:23];

    logic [31:0]       tx_id_reg;
    logic [6:0]        hop_ch1_reg, hop_ch2_reg;
    rclb_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              hop_sel_reg, hop_sel_next;
    logic [2:0]        power_reg, power_next;
    logic              item_hop_reg, item_hop_next;
    logic [2:0]        item_power_reg, item_power_next;
    logic              item_mark_reg, item_mark_next;

    logic [15:0]                   words_reg [rclb_pkg::NUM_STICKS];
    logic [rclb_pkg::MAG_W-1:0]    mag_reg;
    logic                          neg_reg;
    logic [SIDX_W-1:0]             sidx_reg;
    logic [rclb_pkg::PROD_W-1:0]   p1_reg;
    logic [P2_W-1:0]               p2_reg;

    logic              out_valid_reg;
    rclb_pkg::act_t    out_act_reg, emit_act;
    logic [15:0]       out_val_reg, emit_val;
    logic [4:0]        out_pos_reg, emit_pos;
    logic              out_last_reg, emit_last;

    logic [7:0]  cnt_inc;
    logic        tick_accept;
    logic [16:0] quo;
    logic [17:0] quo_s;
    logic [17:0] word_sum;
    logic [15:0] word_sel;
    logic [7:0]  word_byte;

    function automatic logic [7:0] id_byte(input logic [31:0] id, input logic [1:0] sel);
        return id[{sel, 3'b000} +: 8];
    endfunction

    assign status.op         = s_tuser;
    assign status.phase      = phase_reg;
    assign status.rx_ready   = in_rx_ready;
    assign status.rx_match   = (in_rx_byte == rclb_pkg::BIND_MATCH);
    assign status.power_diff = (power_reg != in_power);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign cnt_inc     = cnt_reg + 8'd1;
    assign tick_accept = cmd.accept && (s_tuser == rclb_pkg::OP_TICK);

    // link state update, decided when the item is taken
    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        hop_sel_next    = hop_sel_reg;
        power_next      = power_reg;
        item_hop_next   = item_hop_reg;
        item_power_next = item_power_reg;
        item_mark_next  = item_mark_reg;
        if (cmd.accept && (s_tuser == rclb_pkg::OP_START))
        begin
            phase_next   = in_bind ? rclb_pkg::PH_BIND0 : rclb_pkg::PH_DATA0;
            hop_sel_next = 1'b0;
            power_next   = in_power;
        end
        else if (tick_accept)
        begin
            case (phase_reg)
                rclb_pkg::PH_BIND0, rclb_pkg::PH_BIND1:
                begin
                    if (status.rx_ready && status.rx_match)
                    begin
                        phase_next = rclb_pkg::PH_BIND2_WAIT;
                        cnt_next   = 8'd0;
                    end
                    else
                    begin
                        phase_next = rclb_pkg::PH_BIND1;
                    end
                end
                rclb_pkg::PH_BIND2_WAIT:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == rclb_pkg::BIND_HOLD_TICKS)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = rclb_pkg::PH_BIND2;
                    end
                end
                rclb_pkg::PH_BIND2:
                begin
                    cnt_next       = cnt_inc;
                    item_mark_next = (cnt_inc == rclb_pkg::BIND_FRAMES);
                    if (cnt_inc == rclb_pkg::BIND_FRAMES)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = rclb_pkg::PH_DATA0_WAIT;
                    end
                end
                rclb_pkg::PH_DATA0_WAIT:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == rclb_pkg::BIND_TAIL_TICKS)
                        phase_next = rclb_pkg::PH_DATA0;
                end
                rclb_pkg::PH_DATA0, rclb_pkg::PH_DATA1, rclb_pkg::PH_DATA4:
                begin
                    item_hop_next = hop_sel_reg;
                    hop_sel_next  = ~hop_sel_reg;
                    phase_next    = rclb_pkg::PH_DATA2;
                end
                rclb_pkg::PH_DATA2, rclb_pkg::PH_DATA3:
                begin
                    item_power_next = in_power;
                    power_next      = in_power;
                    phase_next      = (phase_reg == rclb_pkg::PH_DATA2) ?
                                      rclb_pkg::PH_DATA3 : rclb_pkg::PH_DATA4;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // scaled stick word: truncate toward zero, add offset, shift by three
    assign quo      = 17'(p2_reg >> K_SHIFT);
    assign quo_s    = neg_reg ? (18'd0 - {1'b0, quo}) : {1'b0, quo};
    assign word_sum = quo_s + 18'(rclb_pkg::SCALE_OFFSET);

    assign word_sel  = words_reg[cmd.idx[3:1]];
    assign word_byte = cmd.idx[0] ? word_sel[7:0] : word_sel[15:8];

    // result for the current sequencer slot
    always_comb
    begin
        emit_act  = rclb_pkg::ACT_WAIT;
        emit_val  = 16'd0;
        emit_pos  = 5'd0;
        emit_last = 1'b0;
        case (cmd.em)
            rclb_pkg::EM_PRE:
            begin
                case (cmd.idx[1:0])
                    2'd0:
                    begin
                        emit_act = rclb_pkg::ACT_RF_CH;
                        emit_val = 16'(rclb_pkg::RF_BIND_CH);
                    end
                    2'd1:
                    begin
                        emit_act = rclb_pkg::ACT_RATE;
                        emit_val = rclb_pkg::RATE_1M;
                    end
                    default:
                    begin
                        emit_act = rclb_pkg::ACT_MODE;
                        emit_val = rclb_pkg::MODE_RX;
                    end
                endcase
            end
            rclb_pkg::EM_READ:
                emit_act = rclb_pkg::ACT_READ;
            rclb_pkg::EM_MATCH:
            begin
                emit_act = rclb_pkg::ACT_MODE;
                emit_val = cmd.idx[0] ? rclb_pkg::MODE_TX : rclb_pkg::MODE_OFF;
            end
            rclb_pkg::EM_BDONE:
            begin
                case (cmd.idx[1:0])
                    2'd0:
                        emit_act = rclb_pkg::ACT_BIND_DONE;
                    2'd1:
                    begin
                        emit_act = rclb_pkg::ACT_RATE;
                        emit_val = rclb_pkg::RATE_250K;
                    end
                    2'd2:
                    begin
                        emit_act = rclb_pkg::ACT_MODE;
                        emit_val = rclb_pkg::MODE_OFF;
                    end
                    default:
                    begin
                        emit_act = rclb_pkg::ACT_MODE;
                        emit_val = rclb_pkg::MODE_TX;
                    end
                endcase
            end
            rclb_pkg::EM_ADDR:
            begin
                emit_act = rclb_pkg::ACT_ADDR;
                emit_val = {8'd0, id_byte(tx_id_reg, cmd.idx[1:0]) + {7'd0, item_hop_reg}};
                emit_pos = cmd.idx;
            end
            rclb_pkg::EM_RFCH:
            begin
                emit_act = rclb_pkg::ACT_RF_CH;
                emit_val = {9'd0, item_hop_reg ? hop_ch2_reg : hop_ch1_reg};
            end
            rclb_pkg::EM_FLUSH:
                emit_act = rclb_pkg::ACT_FLUSH;
            rclb_pkg::EM_PAY:
            begin
                emit_act = rclb_pkg::ACT_PAYLOAD;
                emit_pos = cmd.idx;
                if (cmd.idx[4])
                    emit_val = {8'd0, id_byte(tx_id_reg, ~cmd.idx[1:0])};
                else
                    emit_val = {8'd0, word_byte};
            end
            rclb_pkg::EM_BPAY:
            begin
                emit_act = rclb_pkg::ACT_PAYLOAD;
                emit_pos = cmd.idx;
                if (cmd.idx[4])
                    emit_val = {8'd0, id_byte(tx_id_reg, ~cmd.idx[1:0])};
                else if (cmd.idx == 5'd15)
                    emit_val = {8'd0, item_mark_reg ? rclb_pkg::BIND_MATCH : rclb_pkg::BIND_MARK};
                else
                    emit_val = {8'd0, rclb_pkg::BIND_FILL};
            end
            rclb_pkg::EM_POWER:
            begin
                emit_act = rclb_pkg::ACT_POWER;
                emit_val = {13'd0, item_power_reg};
            end
            rclb_pkg::EM_WAIT:
            begin
                emit_act  = rclb_pkg::ACT_WAIT;
                emit_val  = rclb_pkg::wait_us(cmd.wsel);
                emit_last = 1'b1;
            end
            default:
                emit_act = rclb_pkg::ACT_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg      <= 32'd0;
            hop_ch1_reg    <= 7'd4;
            hop_ch2_reg    <= 7'd8;
            phase_reg      <= rclb_pkg::PH_DATA0;
            cnt_reg        <= 8'd0;
            hop_sel_reg    <= 1'b0;
            power_reg      <= 3'd0;
            item_hop_reg   <= 1'b0;
            item_power_reg <= 3'd0;
            item_mark_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < rclb_pkg::NUM_STICKS; i++)
                words_reg[i] <= WORD_ZERO;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rclb_pkg::CFG_TX_ID: tx_id_reg   <= cfg_data;
                    rclb_pkg::CFG_HOP1:  hop_ch1_reg <= cfg_data[6:0];
                    rclb_pkg::CFG_HOP2:  hop_ch2_reg <= cfg_data[6:0];
                    default:             tx_id_reg   <= tx_id_reg;
                endcase
            end
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            hop_sel_reg    <= hop_sel_next;
            power_reg      <= power_next;
            item_hop_reg   <= item_hop_next;
            item_power_reg <= item_power_next;
            item_mark_reg  <= item_mark_next;
            if (cmd.scale3)
                words_reg[sidx_reg] <= {word_sum[12:0], 3'b000};
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (s_tuser == rclb_pkg::OP_STORE))
        begin
            sidx_reg <= in_chidx;
            neg_reg  <= in_value[rclb_pkg::MAG_W-1];
            mag_reg  <= in_value[rclb_pkg::MAG_W-1] ? (~in_value + 15'd1) : in_value;
        end
        if (cmd.scale1)
            p1_reg <= rclb_pkg::PROD_W'({8'd0, mag_reg} * 23'(rclb_pkg::SCALE_GAIN));
        if (cmd.scale2)
            p2_reg <= {{RECIP_W{1'b0}}, p1_reg} * {{rclb_pkg::PROD_W{1'b0}}, RECIP};
        if (cmd.emit)
        begin
            out_act_reg  <= emit_act;
            out_val_reg  <= emit_val;
            out_pos_reg  <= emit_pos;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pos_reg, out_val_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: sv/rc_link_bind_and_hop_sequencer.sv
// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  ---------------------------------------------
// cfg       in   cfg_we (no wait)       cfg_index, cfg_data: id, hop channel 1 and 2
// s_*       in   s_tvalid / s_tready    tuser op, tdata item fields
// m_*       out  m_tvalid / m_tready    tuser action, tdata value and byte position
//
// Cycles: one beat in, then one result beat per cycle while m_tready is high; a data
// frame tick gives up to 23 beats. A store beat runs the three-step scaling multiply.
// The action sequencer issues one result per cycle while the output register is free.
// Reset: rst_n async low; the link starts in the data start phase, all sticks at zero.
// Stalls: m_tready low holds the output register and the sequencer; s_tready is high
// only when no run is in progress.
`default_nettype none
module rc_link_bind_and_hop_sequencer #(
    parameter int CHANNEL_FULL_SCALE = 10000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] bind_request, [3:1] power_level, [6:4] channel_index,
    // [21:7] channel_value, [22] rx_ready, [30:23] rx_last_byte, [31] zero
    input  wire logic [31:0] s_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] action_value, [20:16] byte_position, [23:21] zero
    output logic [23:0]      m_tdata,
    // [3:0] action
    output logic [3:0]       m_tuser,
    // last_action: set on the closing wait of each run
    output logic             m_tlast
);

    rclb_pkg::ctl_cmd_t   cmd;
    rclb_pkg::dp_status_t status;

    // sequencer: picks the run of actions for each start or tick beat and steps through it
    rclb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: link state, stick words, config, result register
    rclb_dpath #(
        .CHANNEL_FULL_SCALE (CHANNEL_FULL_SCALE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// File: sv/rclb_checker.sv
`default_nettype none
`include "rc_link_bind_and_hop_sequencer_macros.svh"
module rclb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast
);

    logic out_stall;
    logic run_accept;

    assign out_stall  = m_tvalid && !m_tready;
    assign run_accept = s_tvalid && s_tready &&
                        (s_tuser == rclb_pkg::OP_START || s_tuser == rclb_pkg::OP_TICK);

    // a stalled result beat holds
`RCLB_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

    // every run closes with a wait, and only a wait closes it
`RCLB_ASSERT_NOW(a_last_is_wait, m_tvalid, m_tlast == (m_tuser == rclb_pkg::ACT_WAIT))

    // a start or tick beat blocks the input until its run is out
`RCLB_ASSERT_NEXT(a_busy_after_run, run_accept, !s_tready)

    // byte positions stay inside the frame
`RCLB_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[20:16] <= 5'(rclb_pkg::FRAME_BYTES - 1))

endmodule

bind rc_link_bind_and_hop_sequencer rclb_checker u_rclb_checker (.*);
`default_nettype wire

// File: tb/tb_rc_link_bind_and_hop_sequencer.sv
`timescale 1ns / 100ps
module tb_rc_link_bind_and_hop_sequencer;

    localparam int FULL_SCALE = 10000;

    // Op code that the block ignores: no result, no state change.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Delay until the next tick, carried by the closing wait of each run.
    localparam logic [15:0] WAIT_START_US  = 16'd50000;
    localparam logic [15:0] WAIT_LISTEN_US = 16'd1000;
    localparam logic [15:0] WAIT_SLOW_US   = 16'd10000;
    localparam logic [15:0] WAIT_BIND_US   = 16'd22520;
    localparam logic [15:0] WAIT_HOP_US    = 16'd2000;
    localparam logic [15:0] WAIT_FRAME_US  = 16'd5000;
    localparam logic [15:0] WAIT_NONE_US   = 16'd0;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off for back pressure
    localparam int MAX_PRINTS   = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    rc_link_bind_and_hop_sequencer #(
        .CHANNEL_FULL_SCALE(FULL_SCALE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // One expected radio action, as it should leave the master side.
    typedef struct {
        rclb_pkg::act_t action;
        logic [15:0]    value;
        logic [4:0]     pos;
        logic           closing;
    } link_action_t;

    link_action_t radio_actions_q[$];

    // Shadow copy of the link state and the registers.
    rclb_pkg::phase_t lk_phase;
    logic [7:0]       lk_count;
    logic             lk_hop;
    logic [14:0]      lk_stick [rclb_pkg::NUM_STICKS];
    logic [2:0]       lk_power;
    logic [31:0]      cfg_id;
    logic [6:0]       cfg_hop_a;
    logic [6:0]       cfg_hop_b;

    int err_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    int hold_seen;
    int hold_left;

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Link predictor
    // ------------------------------------------------------------------
    function automatic void queue_action(input rclb_pkg::act_t a, input logic [15:0] v,
                                         input logic [4:0] p, input logic closing);
        link_action_t item;
        item.action  = a;
        item.value   = v;
        item.pos     = p;
        item.closing = closing;
        radio_actions_q.push_back(item);
    endfunction

    // Stick word as sent on air: (v*497/full scale + 1497) * 8, low 16 bits.
    function automatic logic [15:0] stick_word(input int ch);
        int v;
        int q;
        v = int'($signed(lk_stick[ch]));
        q = (v * rclb_pkg::SCALE_GAIN) / FULL_SCALE + rclb_pkg::SCALE_OFFSET;
        return 16'(q << 3);
    endfunction

    // Switch address and RF channel to the current hop, then flip the hop.
    function automatic void hop_actions();
        for (int i = 0; i < 4; i++)
            queue_action(rclb_pkg::ACT_ADDR, {8'h00, 8'(cfg_id[8*i +: 8] + lk_hop)},
                         5'(i), 1'b0);
        queue_action(rclb_pkg::ACT_RF_CH, {9'd0, lk_hop ? cfg_hop_b : cfg_hop_a},
                     5'd0, 1'b0);
        lk_hop   = ~lk_hop;
        lk_phase = rclb_pkg::PH_DATA2;
    endfunction

    // Reversed id trails both bind frames and data frames.
    function automatic void id_tail_actions();
        for (int i = 0; i < 4; i++)
            queue_action(rclb_pkg::ACT_PAYLOAD, {8'h00, cfg_id[8*(3-i) +: 8]},
                         5'(16 + i), 1'b0);
    endfunction

    function automatic void predict_beat(input logic [1:0] op, input logic [31:0] d);
        logic [2:0]  pwr;
        logic [15:0] delay;
        logic [15:0] w;
        pwr   = d[3:1];
        delay = WAIT_NONE_US;
        case (op)
            rclb_pkg::OP_START:
            begin
                lk_phase = d[0] ? rclb_pkg::PH_BIND0 : rclb_pkg::PH_DATA0;
                lk_hop   = 1'b0;
                lk_power = pwr;
                queue_action(rclb_pkg::ACT_WAIT, WAIT_START_US, 5'd0, 1'b1);
            end
            rclb_pkg::OP_STORE:
                lk_stick[d[6:4]] = d[21:7];
            rclb_pkg::OP_TICK:
            begin
                case (lk_phase)
                    rclb_pkg::PH_BIND0, rclb_pkg::PH_BIND1:
                    begin
                        // First listen tick sets up the receiver, then fall into listening.
                        if (lk_phase == rclb_pkg::PH_BIND0)
                        begin
                            queue_action(rclb_pkg::ACT_RF_CH, {9'd0, rclb_pkg::RF_BIND_CH},
                                         5'd0, 1'b0);
                            queue_action(rclb_pkg::ACT_RATE, rclb_pkg::RATE_1M, 5'd0, 1'b0);
                            queue_action(rclb_pkg::ACT_MODE, rclb_pkg::MODE_RX, 5'd0, 1'b0);
                            lk_phase = rclb_pkg::PH_BIND1;
                        end
                        delay = WAIT_LISTEN_US;
                        if (d[22])
                        begin
                            queue_action(rclb_pkg::ACT_READ, 16'd0, 5'd0, 1'b0);
                            if (d[30:23] == rclb_pkg::BIND_MATCH)
                            begin
                                lk_phase = rclb_pkg::PH_BIND2_WAIT;
                                queue_action(rclb_pkg::ACT_MODE, rclb_pkg::MODE_OFF,
                                             5'd0, 1'b0);
                                queue_action(rclb_pkg::ACT_MODE, rclb_pkg::MODE_TX,
                                             5'd0, 1'b0);
                                lk_count = 8'd0;
                                delay    = WAIT_SLOW_US;
                            end
                        end
                    end
                    rclb_pkg::PH_BIND2_WAIT:
                    begin
                        lk_count++;
                        if (lk_count == rclb_pkg::BIND_HOLD_TICKS)
                        begin
                            lk_count = 8'd0;
                            lk_phase = rclb_pkg::PH_BIND2;
                        end
                        delay = WAIT_SLOW_US;
                    end
                    rclb_pkg::PH_BIND2:
                    begin
                        lk_count++;
                        for (int i = 0; i < 15; i++)
                            queue_action(rclb_pkg::ACT_PAYLOAD, {8'h00, rclb_pkg::BIND_FILL},
                                         5'(i), 1'b0);
                        queue_action(rclb_pkg::ACT_PAYLOAD,
                                     {8'h00, (lk_count == rclb_pkg::BIND_FRAMES) ?
                                      rclb_pkg::BIND_MATCH : rclb_pkg::BIND_MARK},
                                     5'd15, 1'b0);
                        id_tail_actions();
                        if (lk_count == rclb_pkg::BIND_FRAMES)
                        begin
                            lk_phase = rclb_pkg::PH_DATA0_WAIT;
                            lk_count = 8'd0;
                        end
                        delay = WAIT_BIND_US;
                    end
                    rclb_pkg::PH_DATA0_WAIT:
                    begin
                        lk_count++;
                        if (lk_count == rclb_pkg::BIND_TAIL_TICKS)
                            lk_phase = rclb_pkg::PH_DATA0;
                        delay = WAIT_SLOW_US;
                    end
                    rclb_pkg::PH_DATA0:
                    begin
                        queue_action(rclb_pkg::ACT_BIND_DONE, 16'd0, 5'd0, 1'b0);
                        queue_action(rclb_pkg::ACT_RATE, rclb_pkg::RATE_250K, 5'd0, 1'b0);
                        queue_action(rclb_pkg::ACT_MODE, rclb_pkg::MODE_OFF, 5'd0, 1'b0);
                        queue_action(rclb_pkg::ACT_MODE, rclb_pkg::MODE_TX, 5'd0, 1'b0);
                        hop_actions();
                        delay = WAIT_HOP_US;
                    end
                    rclb_pkg::PH_DATA1, rclb_pkg::PH_DATA4:
                    begin
                        hop_actions();
                        delay = WAIT_HOP_US;
                    end
                    rclb_pkg::PH_DATA2, rclb_pkg::PH_DATA3:
                    begin
                        queue_action(rclb_pkg::ACT_FLUSH, 16'd0, 5'd0, 1'b0);
                        for (int ch = 0; ch < rclb_pkg::NUM_STICKS; ch++)
                        begin
                            w = stick_word(ch);
                            queue_action(rclb_pkg::ACT_PAYLOAD, {8'h00, w[15:8]},
                                         5'(2*ch), 1'b0);
                            queue_action(rclb_pkg::ACT_PAYLOAD, {8'h00, w[7:0]},
                                         5'(2*ch + 1), 1'b0);
                        end
                        id_tail_actions();
                        // Re-issue power only on a change.
                        if (lk_power != pwr)
                        begin
                            lk_power = pwr;
                            queue_action(rclb_pkg::ACT_POWER, {13'd0, pwr}, 5'd0, 1'b0);
                        end
                        lk_phase = rclb_pkg::phase_t'(lk_phase + 4'd1);
                        delay    = WAIT_FRAME_US;
                    end
                    default:
                        delay = WAIT_NONE_US;
                endcase
                queue_action(rclb_pkg::ACT_WAIT, delay, 5'd0, 1'b1);
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Master side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_asked != hold_seen)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result beat with the oldest expected action.
    always @(posedge clk)
    begin
        link_action_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (radio_actions_q.size() == 0)
                report_mismatch($sformatf("unexpected beat action=%0d value=%0d",
                                          m_tuser, m_tdata[15:0]));
            else
            begin
                want = radio_actions_q.pop_front();
                if (m_tuser !== want.action)
                    report_mismatch($sformatf("action %0d, want %0d", m_tuser, want.action));
                if (m_tdata[15:0] !== want.value)
                    report_mismatch($sformatf("action %0d value %0d, want %0d",
                                              want.action, m_tdata[15:0], want.value));
                if (m_tdata[20:16] !== want.pos)
                    report_mismatch($sformatf("action %0d position %0d, want %0d",
                                              want.action, m_tdata[20:16], want.pos));
                if (m_tlast !== want.closing)
                    report_mismatch($sformatf("action %0d last %0b, want %0b",
                                              want.action, m_tlast, want.closing));
            end
        end
    end

    // ------------------------------------------------------------------
    // Slave side driving
    // ------------------------------------------------------------------

    // Random filler for the fields an op does not look at; bit 31 is padding.
    function automatic logic [31:0] rand_fields();
        return {1'b0, 31'($urandom())};
    endfunction

    // Offer one beat after a random gap, hold it until taken, then predict.
    task automatic send_beat(input logic [1:0] op, input logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(op, d);
    endtask

    task automatic send_start(input logic bind_req, input logic [2:0] pwr);
        logic [31:0] d;
        d      = rand_fields();
        d[0]   = bind_req;
        d[3:1] = pwr;
        send_beat(rclb_pkg::OP_START, d);
    endtask

    task automatic send_store(input logic [2:0] idx, input logic [14:0] val);
        logic [31:0] d;
        d       = rand_fields();
        d[6:4]  = idx;
        d[21:7] = val;
        send_beat(rclb_pkg::OP_STORE, d);
    endtask

    task automatic send_tick(input logic [2:0] pwr, input logic rx_rdy, input logic [7:0] rx_byte);
        logic [31:0] d;
        d        = rand_fields();
        d[3:1]   = pwr;
        d[22]    = rx_rdy;
        d[30:23] = rx_byte;
        send_beat(rclb_pkg::OP_TICK, d);
    endtask

    // Drop valid, wait out every pending result, then let the block settle.
    task automatic drain_link();
        s_tvalid <= 1'b0;
        while (radio_actions_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles; only call when idle.
    task automatic write_link_config(input logic [31:0] id, input logic [31:0] hop_a,
                                     input logic [31:0] hop_b);
        cfg_we    <= 1'b1;
        cfg_index <= rclb_pkg::CFG_TX_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= rclb_pkg::CFG_HOP1;
        cfg_data  <= hop_a;
        @(posedge clk);
        cfg_index <= rclb_pkg::CFG_HOP2;
        cfg_data  <= hop_b;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_id    = id;
        cfg_hop_a = hop_a[6:0];
        cfg_hop_b = hop_b[6:0];
    endtask

    function automatic logic [14:0] rand_stick();
        case ($urandom_range(9))
            0:       return 15'h4000;   // most negative
            1:       return 15'h3FFF;   // most positive
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic logic [2:0] rand_power();
        return $urandom_range(1) ? lk_power : 3'($urandom_range(7));
    endfunction

    // Mostly data-mode traffic: ticks, stick updates, the odd restart.
    task automatic run_data_mix(input int n_items);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_tick(rand_power(), 1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (r < 85)
                send_store(3'($urandom_range(7)), rand_stick());
            else if (r < 93)
                send_start($urandom_range(3) == 0, 3'($urandom_range(7)));
            else
            begin
                // ignored by the block, so it does not count
                send_beat(OP_UNUSED, rand_fields());
                sent--;
            end
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every op, and each corner of the listen and frame logic.
    task automatic test_directed_basics();
        send_idle_pct = 35;
        recv_idle_pct = 70;
        write_link_config(32'd0, 32'd4, 32'd8);
        send_store(3'd0, 15'h3FFF);
        send_store(3'd1, 15'h4000);
        send_store(3'd2, 15'(12500));
        send_store(3'd3, 15'(-12500));
        send_store(3'd7, 15'h7FFF);
        send_beat(OP_UNUSED, 32'h7FFF_FFFF);
        send_tick(3'd0, 1'b0, 8'h00);            // data start straight out of reset
        send_start(1'b0, 3'd5);
        send_tick(3'd5, 1'b0, 8'h00);            // bind done, rate, mode, first hop
        send_tick(3'd5, 1'b0, 8'h00);            // frame, power unchanged
        send_tick(3'd2, 1'b0, 8'h00);            // frame, power re-issued
        send_tick(3'd2, 1'b1, rclb_pkg::BIND_MATCH); // hop; rx fields ignored here
        send_tick(3'd0, 1'b1, 8'hFF);            // frame, power to zero
        send_start(1'b1, 3'd7);
        send_tick(3'd7, 1'b0, 8'h00);            // receiver set-up, no frame
        send_tick(3'd7, 1'b1, 8'hFF);            // frame read, no match
        send_tick(3'd7, 1'b1, 8'h00);
        send_tick(3'd7, 1'b1, 8'h12);
        send_tick(3'd7, 1'b0, rclb_pkg::BIND_MATCH); // match byte but nothing received
        send_tick(3'd7, 1'b1, rclb_pkg::BIND_MATCH); // match: switch to transmit
        send_tick(3'd7, 1'b0, 8'h00);            // hold count
        send_start(1'b0, 3'd0);
        drain_link();
    endtask

    // Whole bind: listen, hold, 20 bind frames, tail wait, into data mode.
    task automatic test_full_bind();
        logic held;
        held = 1'b0;
        write_link_config(32'hFFFF_FFFF, 32'd127, 32'd0);
        send_start(1'b1, 3'($urandom_range(7)));
        repeat (4)
            send_tick(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)));
        while (lk_phase == rclb_pkg::PH_BIND0 || lk_phase == rclb_pkg::PH_BIND1)
            send_tick(3'($urandom_range(7)), 1'b1, rclb_pkg::BIND_MATCH);
        while (lk_phase != rclb_pkg::PH_DATA0)
        begin
            // Stall the receiver through a stretch of bind frames.
            if (lk_phase == rclb_pkg::PH_BIND2 && !held)
            begin
                hold_asked++;
                held = 1'b1;
            end
            if ($urandom_range(9) == 0)
                send_store(3'($urandom_range(7)), rand_stick());
            else
                send_tick(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        repeat (6)
            send_tick(rand_power(), 1'($urandom_range(1)), 8'($urandom_range(255)));
        drain_link();
    endtask

    // Hopping and frames with random id and hop channels.
    task automatic test_data_hops();
        send_idle_pct = 70;
        recv_idle_pct = 35;
        write_link_config($urandom(), $urandom(), $urandom());
        send_start(1'b0, 3'($urandom_range(7)));
        run_data_mix(80);
        drain_link();
    endtask

    // Same traffic with no gaps on either side.
    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_link_config($urandom(), 32'd0, 32'd127);
        send_start(1'b0, 3'($urandom_range(7)));
        run_data_mix(35);
        drain_link();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 2'd0;
        cfg_data  = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = 2'd0;
        m_tready  = 1'b0;
        err_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked = 0;
        hold_seen  = 0;
        hold_left  = 0;

        // Shadow state at its reset values.
        lk_phase  = rclb_pkg::PH_DATA0;
        lk_count  = 8'd0;
        lk_hop    = 1'b0;
        lk_power  = 3'd0;
        cfg_id    = 32'd0;
        cfg_hop_a = 7'd4;
        cfg_hop_b = 7'd8;
        for (int i = 0; i < rclb_pkg::NUM_STICKS; i++)
            lk_stick[i] = 15'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_full_bind();
        test_data_hops();
        test_back_to_back();

        if (err_count == 0)
            $display("PASS rc_link_bind_and_hop_sequencer");
        else
            $display("FAIL rc_link_bind_and_hop_sequencer");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("FAIL rc_link_bind_and_hop_sequencer");
        $finish;
    end

endmodule
